// File: rtl/core/jtl_pkg.sv
package jtl_pkg;

  // Longest document in bytes; positions count up to this value
  localparam int unsigned MAX_DOC_LEN = 65536;
  localparam int unsigned POS_W       = $clog2(MAX_DOC_LEN + 1);
  localparam int unsigned MAX_RES     = 3;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_IDLE    = 3'd1,
    PH_STRING  = 3'd2,
    PH_WORD    = 3'd3,
    PH_NUMBER  = 3'd4,
    PH_DISCARD = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    EV_TOKEN = 2'd0,
    EV_END   = 2'd1,
    EV_ERROR = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    KIND_BRACKET = 3'd0,
    KIND_COLON   = 3'd1,
    KIND_COMMA   = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_WORD    = 3'd4,
    KIND_NUMBER  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_BRACE = 3'd1,
    ERR_BAD_BYTE = 3'd2,
    ERR_OPEN_END = 3'd3,
    ERR_OVERFLOW = 3'd4,
    ERR_TOO_LONG = 3'd5
  } err_e;

  typedef struct packed {
    event_e      ev;
    kind_e       kind;
    logic [7:0]  lead;
    logic [15:0] start_pos;
    logic [15:0] len;
    logic [63:0] value;
    err_e        err;
    logic        last;
  } res_t;

  // Results caused by one beat, valid entries from index 0 up
  typedef struct packed {
    res_t [MAX_RES-1:0] items;
    logic [1:0]         n;
  } step_t;

  function automatic res_t mk_res(event_e ev, kind_e kind, logic [7:0] lead,
                                  logic [15:0] start_pos, logic [15:0] len,
                                  logic [63:0] value, err_e err);
    res_t r;
    r.ev        = ev;
    r.kind      = kind;
    r.lead      = lead;
    r.start_pos = start_pos;
    r.len       = len;
    r.value     = value;
    r.err       = err;
    r.last      = 1'b0;
    return r;
  endfunction

  // Letters of true, null, false by word id and letter index
  function automatic logic [7:0] word_char(logic [1:0] id, logic [2:0] k);
    logic [7:0] c;
    c = 8'h00;
    case (id)
      2'd0: begin
        case (k)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (k)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (k)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] word_len(logic [1:0] id);
    logic [2:0] l;
    case (id)
      2'd0:    l = 3'd4;
      2'd1:    l = 3'd4;
      2'd2:    l = 3'd5;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

endpackage

// File: rtl/core/json_token_lexer.sv
// The first result of a byte is offered in the cycle after its beat is taken.
// Throughput: one byte per cycle while each byte yields at most one result and the
// result port is ready; a byte yielding more results (at most three) holds the input
// until the single result port has drained the three-entry result register.
// Reset (rst_ni low, asynchronous): lexer waits for an opening brace at position
// zero and the result register is emptied.
module json_token_lexer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,   // [7:0] in_byte
  input  logic          s_axis_tlast_i,   // last
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [7:0] lead_char, [23:8] start_pos, [39:24] token_len, [103:40] number_value,
  // [106:104] error_code, [111:107] zero
  output logic [111:0]  m_axis_tdata_o,
  output logic [4:0]    m_axis_tuser_o,   // [1:0] event_res, [4:2] kind
  output logic          m_axis_tlast_o    // last_result
);

  jtl_pkg::step_t step;
  jtl_pkg::res_t  head;
  logic           can_load;
  logic           fire;

  assign s_axis_tready_o = can_load;
  assign fire            = s_axis_tvalid_i && can_load;

  jtl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .step_o (step)
  );

  jtl_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .step_i      (step),
    .pop_ready_i (m_axis_tready_i),
    .can_load_o  (can_load),
    .valid_o     (m_axis_tvalid_o),
    .head_o      (head)
  );

  // pack the head result onto the output beat
  assign m_axis_tdata_o = {5'd0, head.err, head.value, head.len, head.start_pos,
                           head.lead};
  assign m_axis_tuser_o = {head.kind, head.ev};
  assign m_axis_tlast_o = head.last;

endmodule

// File: rtl/core/jtl_core.sv
module jtl_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output jtl_pkg::step_t  step_o
);

  jtl_pkg::phase_e              phase_q, phase_d;
  logic [2:0]                   wprog_q, wprog_d;
  logic [1:0]                   wid_q, wid_d;
  logic [jtl_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [15:0]                  tok_q, tok_d;
  logic [63:0]                  mag_q, mag_d;
  logic                         neg_q, neg_d;
  logic                         seen_q, seen_d;
  logic [7:0]                   lead_q, lead_d;

  jtl_pkg::res_t [jtl_pkg::MAX_RES-1:0] items;
  logic [1:0]                   n;
  logic                         failed;
  logic                         lex_idle;
  jtl_pkg::err_e                err_code;
  logic [15:0]                  pos16;
  logic [jtl_pkg::POS_W-1:0]    pos_inc;
  logic                         is_digit;
  logic [3:0]                   digit;
  logic [67:0]                  cand;
  logic [67:0]                  limit;
  logic [63:0]                  num_q_val;
  logic [63:0]                  num_d_val;

  assign pos16    = pos_q[15:0];
  assign pos_inc  = pos_q + 1'b1;
  assign is_digit = (byte_i >= "0") && (byte_i <= "9");
  assign digit    = 4'(byte_i - "0");

  // mag*10 + d, compared against the signed range for the current sign
  assign cand  = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {64'd0, digit};
  assign limit = neg_q ? (68'd1 << 63) : ((68'd1 << 63) - 68'd1);

  assign num_q_val = neg_q ? (64'd0 - mag_q) : mag_q;
  assign num_d_val = neg_d ? (64'd0 - mag_d) : mag_d;

  // One byte of lexing
  always_comb begin
    phase_d  = phase_q;
    wprog_d  = wprog_q;
    wid_d    = wid_q;
    pos_d    = pos_q;
    tok_d    = tok_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    seen_d   = seen_q;
    lead_d   = lead_q;
    items    = '0;
    n        = 2'd0;
    failed   = 1'b0;
    lex_idle = 1'b0;
    err_code = jtl_pkg::ERR_NONE;

    if (fire_i) begin
      if (phase_q == jtl_pkg::PH_DISCARD) begin
        if (last_i) begin
          phase_d = jtl_pkg::PH_FIRST;
          wprog_d = 3'd0;
          wid_d   = 2'd0;
          pos_d   = '0;
          tok_d   = 16'd0;
          mag_d   = 64'd0;
          neg_d   = 1'b0;
          seen_d  = 1'b0;
          lead_d  = 8'd0;
        end
      end else begin
        if (pos_q >= jtl_pkg::POS_W'(jtl_pkg::MAX_DOC_LEN)) begin
          failed   = 1'b1;
          err_code = jtl_pkg::ERR_TOO_LONG;
        end else begin
          case (phase_q)
            jtl_pkg::PH_FIRST: begin
              if (byte_i != "{") begin
                failed   = 1'b1;
                err_code = jtl_pkg::ERR_NO_BRACE;
              end else begin
                items[n] = jtl_pkg::mk_res(jtl_pkg::EV_TOKEN, jtl_pkg::KIND_BRACKET,
                                           byte_i, pos16, 16'd1, 64'd0, jtl_pkg::ERR_NONE);
                n = n + 2'd1;
                phase_d = jtl_pkg::PH_IDLE;
              end
            end
            jtl_pkg::PH_STRING: begin
              if (byte_i == "\"") begin
                items[n] = jtl_pkg::mk_res(jtl_pkg::EV_TOKEN, jtl_pkg::KIND_STRING,
                                           8'h22, tok_q, pos16 - tok_q, 64'd0,
                                           jtl_pkg::ERR_NONE);
                n = n + 2'd1;
                phase_d = jtl_pkg::PH_IDLE;
              end
            end
            jtl_pkg::PH_WORD: begin
              if ((wprog_q >= jtl_pkg::word_len(wid_q)) ||
                  (jtl_pkg::word_char(wid_q, wprog_q) != byte_i)) begin
                failed   = 1'b1;
                err_code = jtl_pkg::ERR_BAD_BYTE;
              end else begin
                wprog_d = wprog_q + 3'd1;
                if (wprog_d == jtl_pkg::word_len(wid_q)) begin
                  items[n] = jtl_pkg::mk_res(jtl_pkg::EV_TOKEN, jtl_pkg::KIND_WORD,
                                             jtl_pkg::word_char(wid_q, 3'd0), tok_q,
                                             {13'd0, jtl_pkg::word_len(wid_q)}, 64'd0,
                                             jtl_pkg::ERR_NONE);
                  n = n + 2'd1;
                  phase_d = jtl_pkg::PH_IDLE;
                end
              end
            end
            jtl_pkg::PH_NUMBER: begin
              if (is_digit) begin
                if (cand > limit) begin
                  failed   = 1'b1;
                  err_code = jtl_pkg::ERR_OVERFLOW;
                end else begin
                  mag_d  = cand[63:0];
                  seen_d = 1'b1;
                end
              end else if (!seen_q) begin
                failed   = 1'b1;
                err_code = jtl_pkg::ERR_BAD_BYTE;
              end else begin
                // number closes, then this byte is lexed on its own
                items[n] = jtl_pkg::mk_res(jtl_pkg::EV_TOKEN, jtl_pkg::KIND_NUMBER,
                                           lead_q, tok_q, pos16 - tok_q, num_q_val,
                                           jtl_pkg::ERR_NONE);
                n = n + 2'd1;
                phase_d  = jtl_pkg::PH_IDLE;
                lex_idle = 1'b1;
              end
            end
            default: lex_idle = 1'b1;
          endcase
        end

        // Byte between tokens
        if (lex_idle) begin
          case (byte_i)
            "{", "}", "[", "]": begin
              items[n] = jtl_pkg::mk_res(jtl_pkg::EV_TOKEN, jtl_pkg::KIND_BRACKET,
                                         byte_i, pos16, 16'd1, 64'd0, jtl_pkg::ERR_NONE);
              n = n + 2'd1;
            end
            ":": begin
              items[n] = jtl_pkg::mk_res(jtl_pkg::EV_TOKEN, jtl_pkg::KIND_COLON,
                                         byte_i, pos16, 16'd1, 64'd0, jtl_pkg::ERR_NONE);
              n = n + 2'd1;
            end
            ",": begin
              items[n] = jtl_pkg::mk_res(jtl_pkg::EV_TOKEN, jtl_pkg::KIND_COMMA,
                                         byte_i, pos16, 16'd1, 64'd0, jtl_pkg::ERR_NONE);
              n = n + 2'd1;
            end
            "\"": begin
              tok_d   = pos_inc[15:0];
              phase_d = jtl_pkg::PH_STRING;
            end
            "t", "n", "f": begin
              wid_d   = (byte_i == "t") ? 2'd0 : ((byte_i == "n") ? 2'd1 : 2'd2);
              wprog_d = 3'd1;
              tok_d   = pos16;
              phase_d = jtl_pkg::PH_WORD;
            end
            "-", "+": begin
              neg_d   = (byte_i == "-");
              mag_d   = 64'd0;
              seen_d  = 1'b0;
              tok_d   = pos16;
              lead_d  = byte_i;
              phase_d = jtl_pkg::PH_NUMBER;
            end
            " ", 8'h09, 8'h0a: begin
            end
            default: begin
              if (is_digit) begin
                neg_d   = 1'b0;
                mag_d   = {60'd0, digit};
                seen_d  = 1'b1;
                tok_d   = pos16;
                lead_d  = byte_i;
                phase_d = jtl_pkg::PH_NUMBER;
              end else begin
                failed   = 1'b1;
                err_code = jtl_pkg::ERR_BAD_BYTE;
              end
            end
          endcase
        end

        if (failed) begin
          items[n] = jtl_pkg::mk_res(jtl_pkg::EV_ERROR, jtl_pkg::KIND_BRACKET, 8'd0,
                                     pos16, 16'd0, 64'd0, err_code);
          n = n + 2'd1;
          phase_d = jtl_pkg::PH_DISCARD;
        end else if (last_i) begin
          if ((phase_d == jtl_pkg::PH_STRING) || (phase_d == jtl_pkg::PH_WORD) ||
              ((phase_d == jtl_pkg::PH_NUMBER) && !seen_d)) begin
            items[n] = jtl_pkg::mk_res(jtl_pkg::EV_ERROR, jtl_pkg::KIND_BRACKET, 8'd0,
                                       pos16, 16'd0, 64'd0, jtl_pkg::ERR_OPEN_END);
            n = n + 2'd1;
          end else begin
            if (phase_d == jtl_pkg::PH_NUMBER) begin
              items[n] = jtl_pkg::mk_res(jtl_pkg::EV_TOKEN, jtl_pkg::KIND_NUMBER,
                                         lead_d, tok_d, pos_inc[15:0] - tok_d,
                                         num_d_val, jtl_pkg::ERR_NONE);
              n = n + 2'd1;
            end
            items[n] = jtl_pkg::mk_res(jtl_pkg::EV_END, jtl_pkg::KIND_BRACKET, 8'd0,
                                       16'd0, 16'd0, 64'd0, jtl_pkg::ERR_NONE);
            n = n + 2'd1;
          end
        end else begin
          pos_d = pos_inc;
        end

        // a last byte always starts the next document afresh
        if (last_i) begin
          phase_d = jtl_pkg::PH_FIRST;
          wprog_d = 3'd0;
          wid_d   = 2'd0;
          pos_d   = '0;
          tok_d   = 16'd0;
          mag_d   = 64'd0;
          neg_d   = 1'b0;
          seen_d  = 1'b0;
          lead_d  = 8'd0;
        end
      end
    end

    // flag the final result of this beat
    for (int i = 0; i < jtl_pkg::MAX_RES; i++) begin
      items[i].last = (n != 2'd0) && (2'(i) == (n - 2'd1));
    end
  end

  assign step_o.items = items;
  assign step_o.n     = n;

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jtl_pkg::PH_FIRST;
      wprog_q <= 3'd0;
      wid_q   <= 2'd0;
      pos_q   <= '0;
      tok_q   <= 16'd0;
      mag_q   <= 64'd0;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      lead_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      wprog_q <= wprog_d;
      wid_q   <= wid_d;
      pos_q   <= pos_d;
      tok_q   <= tok_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      lead_q  <= lead_d;
    end
  end

endmodule

// File: rtl/core/jtl_outbuf.sv
module jtl_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jtl_pkg::step_t  step_i,
  input  logic            pop_ready_i,
  output logic            can_load_o,
  output logic            valid_o,
  output jtl_pkg::res_t   head_o
);

  jtl_pkg::res_t [jtl_pkg::MAX_RES-1:0] slot_q, slot_d;
  logic [1:0]                           cnt_q, cnt_d;
  logic                                 pop;

  assign valid_o    = (cnt_q != 2'd0);
  assign head_o     = slot_q[0];
  assign pop        = valid_o && pop_ready_i;
  // take a new beat when the buffer is empty or drains this cycle
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_ready_i);

  // load a beat's results or shift one out
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = step_i.items;
      cnt_d  = step_i.n;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
